// ===== src/cvd_pkg.sv =====
// Shared types, constants and helper functions for the Caesar/Vigenere decoder.
package cvd_pkg;

	localparam int KEY_MAX_DEFAULT = 16;
	localparam int KEY_ENTRIES     = 16;
	localparam int LEN_W           = 5;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAESAR_SHIFT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 3'd4;

	localparam logic MODE_CAESAR   = 1'b0;
	localparam logic MODE_VIGENERE = 1'b1;

	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_9       = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] ALPHA_SIZE   = 8'd26;
	localparam logic [7:0] DIGIT_SIZE   = 8'd10;

	// One byte on its way from the input register to the result register.
	typedef struct packed {
		logic [7:0] text;
		logic [4:0] d26;
		logic [3:0] d10;
		logic       bypass;
	} cvd_item_t;

	// Restoring reduction by 26: subtract 208, 104, 52, 26 in turn.
	function automatic logic [4:0] mod26(input logic [7:0] s);
		logic [7:0] r;
		r = s;
		if (r >= 8'd208) r = r - 8'd208;
		if (r >= 8'd104) r = r - 8'd104;
		if (r >= 8'd52)  r = r - 8'd52;
		if (r >= 8'd26)  r = r - 8'd26;
		return r[4:0];
	endfunction

	// Restoring reduction by 10: subtract 160, 80, 40, 20, 10 in turn.
	function automatic logic [3:0] mod10(input logic [7:0] s);
		logic [7:0] r;
		r = s;
		if (r >= 8'd160) r = r - 8'd160;
		if (r >= 8'd80)  r = r - 8'd80;
		if (r >= 8'd40)  r = r - 8'd40;
		if (r >= 8'd20)  r = r - 8'd20;
		if (r >= 8'd10)  r = r - 8'd10;
		return r[3:0];
	endfunction

endpackage

// ===== src/cvd_rotate.sv =====
// Backward rotation of one byte within digits, upper case or lower case; other bytes and zero shifts pass through.
module cvd_rotate import cvd_pkg::*; (
	input  cvd_item_t  item,
	output logic [7:0] plain
);

	logic [7:0] dig_sub;
	logic [7:0] alpha_sub;
	logic [7:0] dig_wrap;
	logic [7:0] alpha_wrap;

	assign dig_sub    = item.text - {4'd0, item.d10};
	assign alpha_sub  = item.text - {3'd0, item.d26};
	assign dig_wrap   = item.text + DIGIT_SIZE - {4'd0, item.d10};
	assign alpha_wrap = item.text + ALPHA_SIZE - {3'd0, item.d26};

	always_comb begin
		priority if (item.bypass) begin
			plain = item.text;
		end else if (item.text >= CHAR_0 && item.text <= CHAR_9) begin
			plain = (dig_sub >= CHAR_0) ? dig_sub : dig_wrap;
		end else if (item.text >= CHAR_UPPER_A && item.text <= CHAR_UPPER_Z) begin
			plain = (alpha_sub >= CHAR_UPPER_A) ? alpha_sub : alpha_wrap;
		end else if (item.text >= CHAR_LOWER_A && item.text <= CHAR_LOWER_Z) begin
			plain = (alpha_sub >= CHAR_LOWER_A) ? alpha_sub : alpha_wrap;
		end else begin
			plain = item.text;
		end
	end

endmodule

// ===== src/caesar_vigenere_decoder_unit.sv =====
// Pipeline: an accepted beat passes the input register and then the result register to the output.
// Throughput: one byte per cycle while the input is not stalled; the key position update is
// the only loop and closes at the input register.
// Stalls: the input stalls only while both stages hold data and the output is stalled.
// Reset: arst_n clears both stage valids, the key position and all configuration registers
// (mode Caesar, shift 0, key length 1, key table zero).
module caesar_vigenere_decoder_unit import cvd_pkg::*; #(
	parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            text_byte,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            plain_byte
);

	localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(KEY_MAX);

	logic                  cipher_mode_q;
	logic [6:0]            caesar_shift_q;
	logic [LEN_W-1:0]      key_length_q;
	logic [CFG_DATA_W-1:0] key_low_q;
	logic [CFG_DATA_W-1:0] key_high_q;
	logic [POS_W-1:0]      key_pos_q;

	logic       valid_s1;
	cvd_item_t  item_s1;
	logic       valid_s2;
	logic [7:0] plain_s2;

	logic             in_acc;
	logic             adv_s2;
	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] cur_pos;
	logic [LEN_W-1:0] use_pos;
	logic [LEN_W-1:0] nxt_pos;
	logic [7:0]       key_entry [KEY_ENTRIES];
	logic [7:0]       shift;
	logic [7:0]       text_in;
	cvd_item_t        item_d;
	logic [7:0]       plain_d;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_mode_q  <= MODE_CAESAR;
			caesar_shift_q <= '0;
			key_length_q   <= LEN_W'(1);
			key_low_q      <= '0;
			key_high_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CIPHER_MODE:  cipher_mode_q  <= cfg_data[0];
				CFG_CAESAR_SHIFT: caesar_shift_q <= cfg_data[6:0];
				CFG_KEY_LENGTH:   key_length_q   <= cfg_data[LEN_W-1:0];
				CFG_KEY_LOW:      key_low_q      <= cfg_data;
				CFG_KEY_HIGH:     key_high_q     <= cfg_data;
				default:          ;
			endcase
		end
	end

	genvar k;
	generate
		for (k = 0; k < KEY_ENTRIES / 2; k++) begin : g_key
			assign key_entry[k]                   = key_low_q[8*k +: 8];
			assign key_entry[k + KEY_ENTRIES / 2] = key_high_q[8*k +: 8];
		end
	endgenerate

	// Key position: clamp the length, fall back to entry 0 if the position is out of range
	always_comb begin
		priority if (key_length_q == '0)
			len_eff = LEN_W'(1);
		else if (key_length_q > LEN_MAX)
			len_eff = LEN_MAX;
		else
			len_eff = key_length_q;
	end

	assign cur_pos = restart ? '0 : LEN_W'(key_pos_q);
	assign use_pos = (cur_pos >= len_eff) ? '0 : cur_pos;
	assign nxt_pos = use_pos + LEN_W'(1);

	assign shift   = (cipher_mode_q == MODE_VIGENERE) ? key_entry[use_pos[3:0]]
	                                                  : {1'b0, caesar_shift_q};
	assign text_in = (cipher_mode_q == MODE_CAESAR && text_byte == CHAR_NEWLINE) ? 8'd0
	                                                                              : text_byte;

	assign item_d.text   = text_in;
	assign item_d.d26    = mod26(shift);
	assign item_d.d10    = mod10(shift);
	assign item_d.bypass = (shift == 8'd0);

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= '0;
		end else if (in_acc) begin
			key_pos_q <= (nxt_pos >= len_eff) ? '0 : nxt_pos[POS_W-1:0];
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s2 || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_d;
		end
	end

	cvd_rotate u_rotate (
		.item  (item_s1),
		.plain (plain_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			plain_s2 <= plain_d;
		end
	end

	assign out_valid  = valid_s2;
	assign plain_byte = plain_s2;

endmodule

// ===== src/cvd_checker.sv =====
// Port-level checks for the decoder, bound to the top level.
module cvd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] plain_byte
);

	// a held result beat keeps its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_byte))
		else $error("stalled output beat changed");

	// back-pressure only comes from a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

	// every accepted beat is followed by a valid result beat once it has passed both registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("accepted beat did not reach the output");

	// no result beat appears without an earlier accepted input beat
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output beat without matching input beat");

endmodule

bind caesar_vigenere_decoder_unit cvd_checker u_cvd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.plain_byte (plain_byte)
);
